/* hw/rtl/dpwp_pkg.sv */
// Shared types and constants for the depth pixel to world point pipeline.
`timescale 1ns / 1ps
package dpwp_pkg;

  localparam int unsigned PixW   = 10;
  localparam int unsigned DepthW = 16;
  localparam int unsigned ColorW = 8;
  localparam int unsigned OutW   = 24;
  localparam int unsigned CfgW   = 63;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned TransW = 21;
  localparam int unsigned ZW     = 20;
  localparam int unsigned CamW   = 34;
  localparam int unsigned ProdW  = 50;
  localparam int unsigned AccW   = 52;
  localparam int unsigned SumW   = 39;
  localparam int unsigned MmToTenths = 10;
  localparam int unsigned Q14Half    = 8192;
  localparam int unsigned Stages     = 7;

  typedef enum logic [2:0] {
    RegInvFocalX   = 3'd0,
    RegInvFocalY   = 3'd1,
    RegOptCentre   = 3'd2,
    RegDepthWindow = 3'd3,
    RegRotRow0     = 3'd4,
    RegRotRow1     = 3'd5,
    RegRotRow2     = 3'd6,
    RegTranslation = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] InvFocalXRst = 32'h006C_84D5;
  localparam logic [31:0] InvFocalYRst = 32'h006D_43B8;
  localparam logic [31:0] OptCentreRst = 32'h0E27_145C;
  localparam logic [31:0] DepthWinRst  = 32'h0640_0000;
  localparam logic [47:0] RotRow0Rst   = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Rst   = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Rst   = 48'h4000_0000_0000;
  localparam logic [62:0] TransRst     = '0;

  typedef logic signed [CamW-1:0] cam_t;

  // stage enables of the back-projection half
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
  } bp_en_t;

  // stage enables of the rotate/translate half
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } xf_en_t;

endpackage

/* hw/rtl/dpwp_backproject.sv */
// One axis of the pinhole back-projection, four register stages.
`timescale 1ns / 1ps
module dpwp_backproject import dpwp_pkg::*; (
  input  logic              clk_i,
  input  bp_en_t            en_i,
  input  logic [PixW-1:0]   pix_i,
  input  logic [15:0]       ctr_i,
  input  logic [DepthW-1:0] depth_i,
  input  logic [31:0]       inv_i,
  output cam_t              cam_o
);

  logic signed [17:0] diff;
  logic signed [17:0] ndiff;
  logic               neg;
  logic [15:0]        mag;
  logic [31:0]        md_q;
  logic [35:0]        p_q;
  logic [51:0]        a_q;
  logic [51:0]        b_q;
  logic [2:0]         neg_q;
  logic [52:0]        t;
  logic [52:0]        rnd;
  logic [32:0]        r;
  cam_t               cam_q;

  assign diff  = $signed({4'b0, pix_i, 4'b0}) - $signed({2'b0, ctr_i});
  assign ndiff = -diff;
  assign neg   = diff[17];
  assign mag   = neg ? ndiff[15:0] : diff[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      md_q     <= 32'(mag) * 32'(depth_i);
      neg_q[0] <= neg;
    end
    if (en_i.s1) begin
      p_q      <= {1'b0, md_q, 3'b0} + {3'b0, md_q, 1'b0};
      neg_q[1] <= neg_q[0];
    end
    if (en_i.s2) begin
      a_q      <= 52'(p_q) * 52'(inv_i[31:16]);
      b_q      <= 52'(p_q) * 52'(inv_i[15:0]);
      neg_q[2] <= neg_q[1];
    end
    if (en_i.s3) begin
      cam_q <= neg_q[2] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    end
  end

  // round to nearest, ties away from zero (applied to the magnitude)
  assign t   = 53'(a_q) + 53'(b_q[51:16]);
  assign rnd = t + 53'(1 << 19);
  assign r   = rnd[52:20];

  assign cam_o = cam_q;

endmodule

/* hw/rtl/dpwp_transform.sv */
// Rotation, Q14 rounding, translation and saturation, three register stages.
`timescale 1ns / 1ps
module dpwp_transform import dpwp_pkg::*; (
  input  logic            clk_i,
  input  xf_en_t          en_i,
  input  cam_t            cam_x_i,
  input  cam_t            cam_y_i,
  input  cam_t            cam_z_i,
  input  logic [47:0]     rot_row0_i,
  input  logic [47:0]     rot_row1_i,
  input  logic [47:0]     rot_row2_i,
  input  logic [CfgW-1:0] trans_i,
  output logic [OutW-1:0] world_x_o,
  output logic [OutW-1:0] world_y_o,
  output logic [OutW-1:0] world_z_o
);

  localparam logic signed [SumW-1:0] OutMax = SumW'(8388607);
  localparam logic signed [SumW-1:0] OutMin = -SumW'(8388608);

  cam_t                     cam    [3];
  logic [47:0]              rot    [3];
  logic signed [ProdW-1:0]  prod_d [3][3];
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [AccW-1:0]   acc_d  [3];
  logic signed [AccW-1:0]   acc_q  [3];
  logic signed [SumW-1:0]   w      [3];
  logic [OutW-1:0]          world_q[3];

  assign cam[0] = cam_x_i;
  assign cam[1] = cam_y_i;
  assign cam[2] = cam_z_i;
  assign rot[0] = rot_row0_i;
  assign rot[1] = rot_row1_i;
  assign rot[2] = rot_row2_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[r][k] = ProdW'($signed(rot[r][CoefW*k +: CoefW])) * ProdW'(cam[k]);
      end
      acc_d[r] = AccW'(prod_q[r][0]) + AccW'(prod_q[r][1]) + AccW'(prod_q[r][2])
               + $signed(AccW'(Q14Half));
      w[r] = SumW'($signed(acc_q[r][AccW-1:14]))
           + SumW'($signed(trans_i[TransW*r +: TransW]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      if (en_i.s4) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= prod_d[r][k];
        end
      end
      if (en_i.s5) begin
        acc_q[r] <= acc_d[r];
      end
      if (en_i.s6) begin
        if (w[r] > OutMax) begin
          world_q[r] <= OutMax[OutW-1:0];
        end else if (w[r] < OutMin) begin
          world_q[r] <= OutMin[OutW-1:0];
        end else begin
          world_q[r] <= w[r][OutW-1:0];
        end
      end
    end
  end

  assign world_x_o = world_q[0];
  assign world_y_o = world_q[1];
  assign world_z_o = world_q[2];

endmodule

/* hw/rtl/depth_pixel_to_world_point.sv */
// A pixel is accepted into stage s0 and its world point is on the output from stage s6 (7 stages).
// Throughput: one pixel per cycle; each of the 7 stages moves when the stage after it is
// free, so a stalled output holds the pipe and bubbles are squeezed out.
// A pixel outside the depth window is accepted and dropped in the first stage.
// Reset clears all stage valid bits and loads the default camera configuration.
`timescale 1ns / 1ps
module depth_pixel_to_world_point import dpwp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixW-1:0]   col_index_i,
  input  logic [PixW-1:0]   row_index_i,
  input  logic [DepthW-1:0] depth_mm_i,
  input  logic [ColorW-1:0] blue_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] red_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OutW-1:0]   world_x_o,
  output logic [OutW-1:0]   world_y_o,
  output logic [OutW-1:0]   world_z_o,
  output logic [ColorW-1:0] out_blue_o,
  output logic [ColorW-1:0] out_green_o,
  output logic [ColorW-1:0] out_red_o
);

  logic [31:0]     inv_fx_q, inv_fy_q, centre_q, dwin_q;
  logic [47:0]     rot0_q, rot1_q, rot2_q;
  logic [CfgW-1:0] trans_q;
  cfg_reg_e        cfg_idx;

  logic [Stages-1:0]     v_q;
  logic [Stages-1:0]     rdy;
  logic                  pass;
  logic [3*ColorW-1:0]   color_q [Stages];
  logic [ZW-1:0]         z_q     [4];
  bp_en_t                bp_en;
  xf_en_t                xf_en;
  cam_t                  cam_x, cam_y;

  assign cfg_idx = cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q <= InvFocalXRst;
      inv_fy_q <= InvFocalYRst;
      centre_q <= OptCentreRst;
      dwin_q   <= DepthWinRst;
      rot0_q   <= RotRow0Rst;
      rot1_q   <= RotRow1Rst;
      rot2_q   <= RotRow2Rst;
      trans_q  <= TransRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        RegInvFocalX:   inv_fx_q <= cfg_wdata_i[31:0];
        RegInvFocalY:   inv_fy_q <= cfg_wdata_i[31:0];
        RegOptCentre:   centre_q <= cfg_wdata_i[31:0];
        RegDepthWindow: dwin_q   <= cfg_wdata_i[31:0];
        RegRotRow0:     rot0_q   <= cfg_wdata_i[47:0];
        RegRotRow1:     rot1_q   <= cfg_wdata_i[47:0];
        RegRotRow2:     rot2_q   <= cfg_wdata_i[47:0];
        RegTranslation: trans_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pass = (depth_mm_i != '0) && (depth_mm_i < dwin_q[31:16])
             && (depth_mm_i > dwin_q[15:0]);

  always_comb begin
    rdy[Stages-1] = ~v_q[Stages-1] | out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i & pass;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      color_q[0] <= {red_i, green_i, blue_i};
      z_q[0]     <= ZW'(depth_mm_i) * ZW'(MmToTenths);
    end
    for (int k = 1; k < Stages; k++) begin
      if (rdy[k]) begin
        color_q[k] <= color_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        z_q[k] <= z_q[k-1];
      end
    end
  end

  assign bp_en = '{s0: rdy[0], s1: rdy[1], s2: rdy[2], s3: rdy[3]};
  assign xf_en = '{s4: rdy[4], s5: rdy[5], s6: rdy[6]};

  dpwp_backproject u_bp_x (
    .clk_i   (clk_i),
    .en_i    (bp_en),
    .pix_i   (col_index_i),
    .ctr_i   (centre_q[15:0]),
    .depth_i (depth_mm_i),
    .inv_i   (inv_fx_q),
    .cam_o   (cam_x)
  );

  dpwp_backproject u_bp_y (
    .clk_i   (clk_i),
    .en_i    (bp_en),
    .pix_i   (row_index_i),
    .ctr_i   (centre_q[31:16]),
    .depth_i (depth_mm_i),
    .inv_i   (inv_fy_q),
    .cam_o   (cam_y)
  );

  dpwp_transform u_xf (
    .clk_i      (clk_i),
    .en_i       (xf_en),
    .cam_x_i    (cam_x),
    .cam_y_i    (cam_y),
    .cam_z_i    (CamW'($signed({1'b0, z_q[3]}))),
    .rot_row0_i (rot0_q),
    .rot_row1_i (rot1_q),
    .rot_row2_i (rot2_q),
    .trans_i    (trans_q),
    .world_x_o  (world_x_o),
    .world_y_o  (world_y_o),
    .world_z_o  (world_z_o)
  );

  assign out_valid_o = v_q[Stages-1];
  assign out_blue_o  = color_q[Stages-1][ColorW-1:0];
  assign out_green_o = color_q[Stages-1][2*ColorW-1:ColorW];
  assign out_red_o   = color_q[Stages-1][3*ColorW-1:2*ColorW];

  // a pixel without a depth reading never enters the pipe
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && depth_mm_i == '0 |=> !v_q[0])
    else $error("zero depth pixel entered pipeline");

  // input is held off only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input stalled with a free stage");

  // a request in the stage before the output moves up when the output drains
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-2] && rdy[Stages-1] |=> v_q[Stages-1])
    else $error("request lost ahead of output stage");

  // a blocked interior stage keeps its request
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && !rdy[3] |=> v_q[3])
    else $error("stalled request dropped");

endmodule

/* dv/tb_depth_pixel_to_world_point.sv */
// Self-checking testbench for the depth pixel to world point pipeline.
`timescale 1ns / 1ps
module tb_depth_pixel_to_world_point;
  import dpwp_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;

  typedef struct packed {
    logic [PixW-1:0]   col;
    logic [PixW-1:0]   row;
    logic [DepthW-1:0] depth;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [OutW-1:0]   x;
    logic [OutW-1:0]   y;
    logic [OutW-1:0]   z;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } world_pt_t;

  typedef struct packed {
    logic [31:0]       inv_fx;
    logic [31:0]       inv_fy;
    logic [31:0]       centre;
    logic [31:0]       window;
    logic [2:0][47:0]  rot;
    logic [CfgW-1:0]   trans;
  } cam_cfg_t;

  localparam cam_cfg_t ResetCfg = '{
    inv_fx: InvFocalXRst, inv_fy: InvFocalYRst, centre: OptCentreRst,
    window: DepthWinRst, rot: {RotRow2Rst, RotRow1Rst, RotRow0Rst}, trans: TransRst
  };

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  cfg_reg_e          cfg_idx_i   = RegInvFocalX;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [PixW-1:0]   col_index_i = '0;
  logic [PixW-1:0]   row_index_i = '0;
  logic [DepthW-1:0] depth_mm_i  = '0;
  logic [ColorW-1:0] blue_i      = '0;
  logic [ColorW-1:0] green_i     = '0;
  logic [ColorW-1:0] red_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [OutW-1:0]   world_x_o;
  logic [OutW-1:0]   world_y_o;
  logic [OutW-1:0]   world_z_o;
  logic [ColorW-1:0] out_blue_o;
  logic [ColorW-1:0] out_green_o;
  logic [ColorW-1:0] out_red_o;

  world_pt_t expected_points[$];
  cam_cfg_t  live_cfg     = ResetCfg;
  int        mismatch_cnt = 0;
  int        quiet_cycles = 0;
  int        in_idle_pct  = 14;
  int        out_idle_pct = 64;
  int        hold_req     = 0;
  int        hold_seen    = 0;
  int        hold_left    = 0;

  depth_pixel_to_world_point dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .col_index_i (col_index_i),
    .row_index_i (row_index_i),
    .depth_mm_i  (depth_mm_i),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .world_x_o   (world_x_o),
    .world_y_o   (world_y_o),
    .world_z_o   (world_z_o),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // (diff * d * 10 * inv) / 2^36 with the low partial product truncated, ties away from zero
  function automatic longint project_axis(input longint diff, input longint unsigned d,
                                          input logic [31:0] inv);
    longint unsigned mag, p, hi, lo, t, r;
    mag = (diff < 0) ? -diff : diff;
    p   = mag * d * MmToTenths;
    hi  = p * inv[31:16];
    lo  = p * inv[15:0];
    t   = hi + (lo >> 16);
    r   = (t + (64'd1 << 19)) >> 20;
    return (diff < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit predict_point(input cam_cfg_t c, input pixel_t p,
                                       output world_pt_t pt);
    longint          cam [3];
    longint          acc, w;
    logic [OutW-1:0] coord [3];
    pt = '0;
    if (p.depth == 0 || p.depth >= c.window[31:16] || p.depth <= c.window[15:0])
      return 1'b0;
    cam[0] = project_axis(longint'(p.col) * 16 - longint'(c.centre[15:0]), 64'(p.depth),
                          c.inv_fx);
    cam[1] = project_axis(longint'(p.row) * 16 - longint'(c.centre[31:16]), 64'(p.depth),
                          c.inv_fy);
    cam[2] = longint'(p.depth) * longint'(MmToTenths);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += longint'($signed(c.rot[r][16*k +: 16])) * cam[k];
      // round half up in Q14, then offset and clamp
      w = ((acc + longint'(Q14Half)) >>> 14) + longint'($signed(c.trans[21*r +: 21]));
      if (w > 8388607) w = 8388607;
      else if (w < -8388608) w = -8388608;
      coord[r] = w[OutW-1:0];
    end
    pt = '{x: coord[0], y: coord[1], z: coord[2], blue: p.blue, green: p.green, red: p.red};
    return 1'b1;
  endfunction

  function automatic void count_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : monitor
    pixel_t    px;
    world_pt_t want, got;
    if (!rst_ni) begin
      live_cfg     = ResetCfg;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegInvFocalX:   live_cfg.inv_fx = cfg_wdata_i[31:0];
          RegInvFocalY:   live_cfg.inv_fy = cfg_wdata_i[31:0];
          RegOptCentre:   live_cfg.centre = cfg_wdata_i[31:0];
          RegDepthWindow: live_cfg.window = cfg_wdata_i[31:0];
          RegRotRow0:     live_cfg.rot[0] = cfg_wdata_i[47:0];
          RegRotRow1:     live_cfg.rot[1] = cfg_wdata_i[47:0];
          RegRotRow2:     live_cfg.rot[2] = cfg_wdata_i[47:0];
          RegTranslation: live_cfg.trans  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        quiet_cycles = 0;
        px = '{col: col_index_i, row: row_index_i, depth: depth_mm_i,
               blue: blue_i, green: green_i, red: red_i};
        if (predict_point(live_cfg, px, want)) expected_points = {expected_points, want};
      end
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        got = '{x: world_x_o, y: world_y_o, z: world_z_o,
                blue: out_blue_o, green: out_green_o, red: out_red_o};
        if (expected_points.size() == 0) begin
          count_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d bgr=%h %h %h",
                                   $signed(got.x), $signed(got.y), $signed(got.z),
                                   got.blue, got.green, got.red));
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.blue !== want.blue || got.green !== want.green || got.red !== want.red)
            count_mismatch($sformatf(
              "point mismatch: expected x=%0d y=%0d z=%0d bgr=%h %h %h, got x=%0d y=%0d z=%0d bgr=%h %h %h",
              $signed(want.x), $signed(want.y), $signed(want.z),
              want.blue, want.green, want.red,
              $signed(got.x), $signed(got.y), $signed(got.z),
              got.blue, got.green, got.red));
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin : receiver
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    col_index_i <= p.col;
    row_index_i <= p.row;
    depth_mm_i  <= p.depth;
    blue_i      <= p.blue;
    green_i     <= p.green;
    red_i       <= p.red;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait for every pending point, then let dropped pixels clear the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (Stages + 4) @(posedge clk_i);
  endtask

  task automatic apply_config(input cam_cfg_t c);
    logic [CfgW-1:0] val;
    for (int i = 0; i < 8; i++) begin
      case (cfg_reg_e'(i))
        RegInvFocalX:   val = CfgW'(c.inv_fx);
        RegInvFocalY:   val = CfgW'(c.inv_fy);
        RegOptCentre:   val = CfgW'(c.centre);
        RegDepthWindow: val = CfgW'(c.window);
        RegRotRow0:     val = CfgW'(c.rot[0]);
        RegRotRow1:     val = CfgW'(c.rot[1]);
        RegRotRow2:     val = CfgW'(c.rot[2]);
        default:        val = c.trans;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(i);
      cfg_wdata_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(32'd21474836, 32'd2147483);
    endcase
  endfunction

  function automatic logic [15:0] pick_centre();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom());
      default: return 16'($urandom_range(16368));
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    int v;
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4: return 16'($urandom());
      default: begin
        v = $urandom_range(32768) - 16384;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_offset();
    int v;
    case ($urandom_range(7))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      default: begin
        v = $urandom_range(200000) - 100000;
        return v[20:0];
      end
    endcase
  endfunction

  function automatic cam_cfg_t random_config();
    cam_cfg_t c;
    int unsigned lo, hi;
    c.inv_fx = pick_inv();
    c.inv_fy = pick_inv();
    c.centre = {pick_centre(), pick_centre()};
    case ($urandom_range(9))
      0: c.window = $urandom();
      1: c.window = {16'hFFFF, 16'h0000};
      default: begin
        lo = $urandom_range(2000);
        hi = lo + $urandom_range(20000, 2);
        c.window = {hi[15:0], lo[15:0]};
      end
    endcase
    for (int r = 0; r < 3; r++)
      c.rot[r] = {pick_coef(), pick_coef(), pick_coef()};
    c.trans = {pick_offset(), pick_offset(), pick_offset()};
    return c;
  endfunction

  // mostly depths inside the window, the rest zero, boundary or anything
  function automatic pixel_t random_pixel(input cam_cfg_t c);
    pixel_t p;
    int unsigned lo, hi;
    lo = {16'b0, c.window[15:0]};
    hi = {16'b0, c.window[31:16]};
    p.col   = 10'($urandom());
    p.row   = 10'($urandom());
    p.blue  = 8'($urandom());
    p.green = 8'($urandom());
    p.red   = 8'($urandom());
    if (hi > lo + 1 && $urandom_range(99) < 85) begin
      p.depth = 16'($urandom_range(hi - 1, lo + 1));
    end else begin
      case ($urandom_range(3))
        0: p.depth = '0;
        1: p.depth = lo[15:0];
        2: p.depth = hi[15:0];
        default: p.depth = 16'($urandom());
      endcase
    end
    return p;
  endfunction

  task automatic test_reset_config();
    send_pixel('{col: 0, row: 0, depth: 1, blue: 8'h00, green: 8'h00, red: 8'h00});
    send_pixel('{col: 1023, row: 1023, depth: 1599, blue: 8'hFF, green: 8'hFF, red: 8'hFF});
    send_pixel('{col: 512, row: 384, depth: 0, blue: 8'h11, green: 8'h22, red: 8'h33});
    send_pixel('{col: 100, row: 200, depth: 1600, blue: 8'h44, green: 8'h55, red: 8'h66});
    send_pixel('{col: 1023, row: 0, depth: 800, blue: 8'h5A, green: 8'hA5, red: 8'h3C});
    send_pixel('{col: 0, row: 1023, depth: 65535, blue: 8'h77, green: 8'h88, red: 8'h99});
  endtask

  task automatic test_depth_window();
    cam_cfg_t cfg;
    cfg = ResetCfg;
    cfg.window = {16'd101, 16'd100};
    settle();
    apply_config(cfg);
    send_pixel('{col: 10, row: 20, depth: 100, blue: 8'h01, green: 8'h02, red: 8'h03});
    send_pixel('{col: 30, row: 40, depth: 101, blue: 8'h04, green: 8'h05, red: 8'h06});
    cfg.window = {16'd1000, 16'd2000};
    settle();
    apply_config(cfg);
    send_pixel('{col: 300, row: 200, depth: 1500, blue: 8'h07, green: 8'h08, red: 8'h09});
    cfg.window = {16'hFFFF, 16'h0000};
    settle();
    apply_config(cfg);
    send_pixel('{col: 1023, row: 1023, depth: 65534, blue: 8'hC3, green: 8'h3C, red: 8'h96});
    send_pixel('{col: 0, row: 0, depth: 1, blue: 8'h69, green: 8'hF0, red: 8'h0F});
    send_pixel('{col: 1, row: 1, depth: 65535, blue: 8'hAA, green: 8'h55, red: 8'hAA});
  endtask

  task automatic test_saturation();
    cam_cfg_t cfg;
    cfg.inv_fx = '1;
    cfg.inv_fy = '1;
    cfg.centre = {16'h0000, 16'hFFFF};
    cfg.window = {16'hFFFF, 16'h0000};
    cfg.rot[0] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    cfg.rot[1] = {16'h8000, 16'h8000, 16'h8000};
    cfg.rot[2] = {16'h8000, 16'h0000, 16'h7FFF};
    cfg.trans  = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
    settle();
    apply_config(cfg);
    send_pixel('{col: 0, row: 1023, depth: 65534, blue: 8'h12, green: 8'h34, red: 8'h56});
    send_pixel('{col: 1023, row: 0, depth: 65534, blue: 8'h78, green: 8'h9A, red: 8'hBC});
    send_pixel('{col: 512, row: 512, depth: 1, blue: 8'hDE, green: 8'hF0, red: 8'h01});
    cfg.rot[0] = {16'h8000, 16'h8000, 16'h8000};
    cfg.rot[1] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    cfg.trans  = {21'h100000, 21'h0FFFFF, 21'h100000};
    settle();
    apply_config(cfg);
    send_pixel('{col: 0, row: 1023, depth: 65534, blue: 8'h23, green: 8'h45, red: 8'h67});
    send_pixel('{col: 1023, row: 0, depth: 65534, blue: 8'h89, green: 8'hAB, red: 8'hCD});
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct);
    cam_cfg_t cfg;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (5) begin
      cfg = random_config();
      settle();
      apply_config(cfg);
      repeat (100) send_pixel(random_pixel(cfg));
    end
  endtask

  // output held off while requests keep coming, so the pipe fills and backs up
  task automatic test_output_hold();
    cam_cfg_t cfg;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    cfg = random_config();
    cfg.window = {16'd60000, 16'd10};
    settle();
    apply_config(cfg);
    hold_req <= hold_req + 1;
    repeat (40) send_pixel(random_pixel(cfg));
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_depth_window();
    test_saturation();
    test_random_traffic(14, 64);
    test_random_traffic(64, 14);
    test_random_traffic(0, 0);
    test_output_hold();
    settle();
    if (mismatch_cnt == 0 && expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
